/* rtl/lfsd_pkg.sv */
package lfsd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned LenMin   = 4;

  localparam logic [ByteW-1:0] NoiseByte      = 8'hFF;
  localparam logic [ByteW-1:0] StartMarkerRst = 8'hBB;
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'h7E;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_RX_ENABLE    = 2'd2,
    REG_NONE         = 2'd3
  } lfsd_reg_e;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD   = 3'd2,
    PH_STAT  = 3'd3,
    PH_PAY   = 3'd4,
    PH_TRAIL = 3'd5,
    PH_END   = 3'd6
  } lfsd_phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2
  } lfsd_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
    logic             rx_enable;
  } lfsd_cfg_t;

  typedef struct packed {
    logic             vld;
    lfsd_kind_e       kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] command_code;
    logic [ByteW-1:0] status_code;
    logic [ByteW-1:0] payload_count;
  } lfsd_res_t;

endpackage

/* rtl/lfsd_parser.sv */
module lfsd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lfsd_pkg::lfsd_cfg_t        cfg_i,
  input  logic                       byte_vld_i,
  input  logic                       step_i,
  input  logic [lfsd_pkg::ByteW-1:0] byte_i,
  output lfsd_pkg::lfsd_res_t        res_o
);
  import lfsd_pkg::*;

  lfsd_phase_e      phase_q, phase_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] stat_q, stat_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] left_dec;
  logic             live;

  // Only enabled, non-noise beats move the parser.
  assign live     = byte_vld_i && cfg_i.rx_enable && (byte_i != NoiseByte);
  assign left_dec = left_q - ByteW'(1);

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    cmd_d   = cmd_q;
    stat_d  = stat_q;
    cnt_d   = cnt_q;
    res_o   = '{vld: 1'b0, kind: KIND_PAYLOAD, default: '0};
    if (live) begin
      unique case (phase_q)
        PH_LEN: begin
          if (byte_i < ByteW'(LenMin)) begin
            phase_d   = PH_WAIT;
            res_o.vld  = 1'b1;
            res_o.kind = KIND_DROP;
          end else begin
            cnt_d   = byte_i - ByteW'(LenMin);
            left_d  = byte_i - ByteW'(LenMin);
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = byte_i;
          phase_d = PH_STAT;
        end
        PH_STAT: begin
          stat_d  = byte_i;
          phase_d = (left_q == '0) ? PH_TRAIL : PH_PAY;
        end
        PH_PAY: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_TRAIL;
          end
          res_o.vld          = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = byte_i;
        end
        PH_TRAIL: begin
          phase_d = PH_END;
        end
        PH_END: begin
          phase_d   = PH_WAIT;
          res_o.vld = 1'b1;
          if (byte_i == cfg_i.end_marker) begin
            res_o.kind          = KIND_ACCEPT;
            res_o.command_code  = cmd_q;
            res_o.status_code   = stat_q;
            res_o.payload_count = cnt_q;
          end else begin
            res_o.kind = KIND_DROP;
          end
        end
        default: begin
          // Wait for start marker; unused codes fall back here.
          left_d  = '0;
          phase_d = (byte_i == cfg_i.start_marker) ? PH_LEN : PH_WAIT;
        end
      endcase
    end
  end

  // Commit the update only when the held beat is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      left_q  <= '0;
      cmd_q   <= '0;
      stat_q  <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      cmd_q   <= cmd_d;
      stat_q  <= stat_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/length_framed_serial_deframer_top.sv */
// Length-framed serial deframer. Received bytes enter on the input channel
// one beat at a time; 0xFF bytes are discarded and, with rx_enable clear,
// every byte is ignored. Frames are: start marker, length L, command,
// status, L-4 payload bytes, one trailer byte, end marker. Each payload byte
// leaves as its own result beat (kind 0) as soon as it arrives; at the end
// marker position a beat of kind 1 (accepted, with command, status and
// payload count) or kind 2 (dropped) closes the frame. A length below 4
// gives a dropped beat at the length byte itself. Downstream must discard
// payload beats of a frame that ends dropped. Each input beat passes the
// input register, then the result register; the block takes one beat per
// cycle unless the output stalls with a result waiting; the per-byte
// parser update is the only logic between those two registers. Registers sit
// on the APB port at byte addresses 0x0 (start marker), 0x4 (end marker) and
// 0x8 (rx_enable); write them only while the block is idle.
module length_framed_serial_deframer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lfsd_pkg::ByteW-1:0]   rx_byte_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lfsd_pkg::KindW-1:0]   out_kind_o,
  output logic [lfsd_pkg::ByteW-1:0]   payload_byte_o,
  output logic [lfsd_pkg::ByteW-1:0]   command_code_o,
  output logic [lfsd_pkg::ByteW-1:0]   status_code_o,
  output logic [lfsd_pkg::ByteW-1:0]   payload_count_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfsd_pkg::PaddrW-1:0]  paddr,
  input  logic [lfsd_pkg::PdataW-1:0]  pwdata,
  output logic [lfsd_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import lfsd_pkg::*;

  lfsd_cfg_t        cfg_q;
  lfsd_reg_e        reg_sel;
  logic             cfg_wr;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             proc;
  logic             advance;
  lfsd_res_t        res;

  logic             out_vld_q;
  lfsd_kind_e       out_kind_q;
  logic [ByteW-1:0] out_pay_q;
  logic [ByteW-1:0] out_cmd_q;
  logic [ByteW-1:0] out_stat_q;
  logic [ByteW-1:0] out_cnt_q;

  // ---------------------------------------------------------------------
  // Configuration registers: zero wait states, word-addressed.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = lfsd_reg_e'(paddr[PaddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker   <= EndMarkerRst;
      cfg_q.rx_enable    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START_MARKER: cfg_q.start_marker <= pwdata[ByteW-1:0];
        REG_END_MARKER:   cfg_q.end_marker   <= pwdata[ByteW-1:0];
        REG_RX_ENABLE:    cfg_q.rx_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_START_MARKER: prdata = PdataW'(cfg_q.start_marker);
      REG_END_MARKER:   prdata = PdataW'(cfg_q.end_marker);
      REG_RX_ENABLE:    prdata = PdataW'(cfg_q.rx_enable);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register. The held beat is consumed when it yields no result or
  // the result register is free or being drained this cycle. The parser
  // always evaluates the held beat and commits its state only on proc.
  // ---------------------------------------------------------------------
  assign advance    = !in_vld_q || !res.vld || !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && advance;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (advance) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lfsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .byte_vld_i(in_vld_q),
    .step_i    (proc),
    .byte_i    (in_byte_q),
    .res_o     (res)
  );

  // ---------------------------------------------------------------------
  // Result register: load a new beat, drop a delivered one, hold on stall.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res.vld) begin
      out_kind_q <= res.kind;
      out_pay_q  <= res.payload_byte;
      out_cmd_q  <= res.command_code;
      out_stat_q <= res.status_code;
      out_cnt_q  <= res.payload_count;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_kind_o      = out_kind_q;
  assign payload_byte_o  = out_pay_q;
  assign command_code_o  = out_cmd_q;
  assign status_code_o   = out_stat_q;
  assign payload_count_o = out_cnt_q;

endmodule
